// ===== src/relay_bank_timed_revert_macros.svh =====
// Assertion macros shared by the relay bank checker.
`ifndef RELAY_BANK_TIMED_REVERT_MACROS_SVH
`define RELAY_BANK_TIMED_REVERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBTR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("relay bank assertion failed");

// Next-cycle implication, disabled during reset.
`define RBTR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("relay bank assertion failed");

`endif

// ===== src/rbtr_pkg.sv =====
// Types and constants shared by the relay bank modules.
package rbtr_pkg;

   localparam int MAX_RELAYS = 8;
   localparam int RELAY_W    = 3;
   localparam int COUNT_W    = 4;
   localparam int NUM_W      = 8;
   localparam int OWNER_W    = 8;
   localparam int HOLD_W     = 8;
   localparam int CNT_W      = 9;
   localparam int WORD_W     = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      FUNC_PLAIN  = 2'd0,
      FUNC_TIMED  = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_STATUS = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_DRIVE  = 2'd0,
      KIND_NOTICE = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      OP_PLAIN       = 3'd0,
      OP_ARM         = 3'd1,
      OP_TIMED_PLAIN = 3'd2,
      OP_TICK        = 3'd3,
      OP_STATUS      = 3'd4
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [RELAY_W-1:0]   idx;
      logic                 new_state;
      logic [OWNER_W-1:0]   requester;
      logic [HOLD_W-1:0]    hold_seconds;
      logic                 notify_wanted;
   } cmd_type;

   typedef struct packed {
      kind_type             kind;
      logic [RELAY_W-1:0]   relay;
      logic                 drive_state;
      logic [OWNER_W-1:0]   owner;
      logic [WORD_W-1:0]    relay_states;
      logic                 last;
   } rsp_type;

endpackage

// ===== src/rbtr_queue.sv =====
// Two-entry command queue between the front and back parts.
module rbtr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbtr_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   input  logic             pop,
   output rbtr_pkg::cmd_type pop_cmd
);
   import rbtr_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/rbtr_front.sv =====
// Front part: accepts requests, drops bad relay numbers and classifies commands.
module rbtr_front #(
   parameter int NREL = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rbtr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic [rbtr_pkg::COUNT_W-1:0]   relay_count,
   input  logic                           q_ready,
   output logic                           q_push,
   output rbtr_pkg::cmd_type              q_cmd
);
   import rbtr_pkg::*;

   logic                 hold_valid_ff, hold_valid_in;
   cmd_type              hold_cmd_ff, hold_cmd_in;
   logic [NUM_W-1:0]     num;
   logic                 rev;
   logic                 bad;
   logic                 accept;
   cmd_type              cls;

   assign req_tready = !hold_valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = hold_valid_ff;
   assign q_cmd      = hold_cmd_ff;

   always_comb begin
      num               = req_tdata[7:0];
      rev               = req_tdata[25];
      cls.idx           = RELAY_W'(num - NUM_W'(1));
      cls.new_state     = req_tdata[8];
      cls.requester     = req_tdata[16:9];
      cls.hold_seconds  = req_tdata[24:17];
      cls.notify_wanted = req_tdata[26];
      case (func_type'(req_tuser))
         FUNC_PLAIN:  cls.op = OP_PLAIN;
         FUNC_TIMED:  cls.op = rev ? OP_ARM : OP_TIMED_PLAIN;
         FUNC_TICK:   cls.op = OP_TICK;
         default:     cls.op = OP_STATUS;
      endcase
      bad = (cls.op == OP_PLAIN || cls.op == OP_ARM || cls.op == OP_TIMED_PLAIN)
            && (num == '0 || num > NUM_W'(relay_count) || num > NUM_W'(NREL));

      hold_valid_in = hold_valid_ff && !q_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = !bad;
         hold_cmd_in   = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

// ===== src/rbtr_back.sv =====
// Back part: keeps the relay state, executes commands and drives the result register.
module rbtr_back #(
   parameter int NREL = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rbtr_pkg::COUNT_W-1:0] relay_count,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  rbtr_pkg::cmd_type            q_cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rbtr_pkg::rsp_type            rsp
);
   import rbtr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SWITCH = 5'b00010,
      ST_NOTE   = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_STATUS = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [NREL-1:0]    cur_ff, cur_in;
   logic [NREL-1:0]    prev_ff, prev_in;
   logic [NREL-1:0]    armed_ff, armed_in;
   logic [NREL-1:0]    note_ff, note_in;
   logic [CNT_W-1:0]   cnt_ff [NREL];
   logic [CNT_W-1:0]   cnt_in [NREL];
   logic [NREL-1:0]    fire_ff, fire_in;
   logic [NREL-1:0]    tell_ff, tell_in;
   logic [RELAY_W-1:0] walk_ff, walk_in;
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free;
   logic               emit;
   rsp_type            pkt;
   logic [NREL-1:0]    sel;
   logic [NREL-1:0]    active;
   logic               cur_sel, armed_sel, note_sel, cnt_nz_sel;
   logic               fire_w, tell_w, cur_w, higher;
   logic               need_note;
   logic               adv;
   logic [CNT_W-1:0]   dec;
   logic [NREL-1:0]    fire_nx, tell_nx;
   logic [WORD_W-1:0]  word;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cur_sel    = 1'b0;
      armed_sel  = 1'b0;
      note_sel   = 1'b0;
      cnt_nz_sel = 1'b0;
      fire_w     = 1'b0;
      tell_w     = 1'b0;
      cur_w      = 1'b0;
      higher     = 1'b0;
      word       = '0;
      for (int i = 0; i < NREL; i++) begin
         sel[i]    = (RELAY_W'(i) == cmd_ff.idx);
         active[i] = (COUNT_W'(i) < relay_count);
         cur_sel    = cur_sel | (sel[i] & cur_ff[i]);
         armed_sel  = armed_sel | (sel[i] & armed_ff[i]);
         note_sel   = note_sel | (sel[i] & note_ff[i]);
         cnt_nz_sel = cnt_nz_sel | (sel[i] & (cnt_ff[i] != '0));
         if (RELAY_W'(i) == walk_ff) begin
            fire_w = fire_ff[i];
            tell_w = tell_ff[i];
            cur_w  = cur_ff[i];
         end
         if (RELAY_W'(i) > walk_ff) begin
            higher = higher | fire_ff[i];
         end
         word[i] = cur_ff[i] & active[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      armed_in     = armed_ff;
      note_in      = note_ff;
      cnt_in       = cnt_ff;
      fire_in      = fire_ff;
      tell_in      = tell_ff;
      walk_in      = walk_ff;
      phase_in     = phase_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      adv          = 1'b0;
      need_note    = 1'b0;
      dec          = '0;
      fire_nx      = '0;
      tell_nx      = '0;
      pkt          = '0;
      pkt.kind     = KIND_DRIVE;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  OP_TICK: begin
                     for (int i = 0; i < NREL; i++) begin
                        dec = (cnt_ff[i] == '0) ? '0 : cnt_ff[i] - CNT_W'(1);
                        if (active[i] && armed_ff[i]) begin
                           cnt_in[i] = dec;
                           if (dec == '0 && prev_ff[i] != cur_ff[i]) begin
                              cur_in[i]   = prev_ff[i];
                              armed_in[i] = 1'b0;
                              note_in[i]  = 1'b0;
                              fire_nx[i]  = 1'b1;
                              tell_nx[i]  = note_ff[i];
                           end
                        end
                     end
                     fire_in  = fire_nx;
                     tell_in  = tell_nx;
                     walk_in  = '0;
                     phase_in = 1'b0;
                     state_in = (fire_nx != '0) ? ST_WALK : ST_IDLE;
                  end
                  OP_STATUS: state_in = ST_STATUS;
                  default:   state_in = ST_SWITCH;
               endcase
            end
         end
         ST_SWITCH: begin
            if (cmd_ff.new_state == cur_sel) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               need_note       = (cmd_ff.op == OP_PLAIN) && armed_sel && cnt_nz_sel
                                 && note_sel;
               emit            = 1'b1;
               pkt.kind        = KIND_DRIVE;
               pkt.relay       = cmd_ff.idx;
               pkt.drive_state = cmd_ff.new_state;
               pkt.last        = !need_note;
               for (int i = 0; i < NREL; i++) begin
                  if (sel[i]) begin
                     prev_in[i] = cur_ff[i];
                     cur_in[i]  = cmd_ff.new_state;
                     if (cmd_ff.op == OP_ARM) begin
                        armed_in[i] = 1'b1;
                        cnt_in[i]   = {1'b0, cmd_ff.hold_seconds} + CNT_W'(1);
                        note_in[i]  = cmd_ff.notify_wanted;
                     end else begin
                        armed_in[i] = 1'b0;
                        cnt_in[i]   = '0;
                        note_in[i]  = 1'b0;
                     end
                  end
               end
               state_in = need_note ? ST_NOTE : ST_IDLE;
            end
         end
         ST_NOTE: begin
            if (out_free) begin
               emit      = 1'b1;
               pkt.kind  = KIND_NOTICE;
               pkt.relay = cmd_ff.idx;
               pkt.owner = cmd_ff.requester;
               pkt.last  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (!fire_w) begin
               adv = 1'b1;
            end else if (!phase_ff) begin
               if (out_free) begin
                  emit            = 1'b1;
                  pkt.kind        = KIND_DRIVE;
                  pkt.relay       = walk_ff;
                  pkt.drive_state = cur_w;
                  pkt.last        = !tell_w && !higher;
                  if (tell_w) begin
                     phase_in = 1'b1;
                  end else begin
                     adv = 1'b1;
                  end
               end
            end else if (out_free) begin
               emit      = 1'b1;
               pkt.kind  = KIND_NOTICE;
               pkt.relay = walk_ff;
               pkt.last  = !higher;
               phase_in  = 1'b0;
               adv       = 1'b1;
            end
            if (adv) begin
               if (higher) begin
                  walk_in = walk_ff + RELAY_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit             = 1'b1;
               pkt.kind         = KIND_STATUS;
               pkt.relay_states = word;
               pkt.last         = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         prev_ff      <= '0;
         armed_ff     <= '0;
         note_ff      <= '0;
         fire_ff      <= '0;
         tell_ff      <= '0;
         walk_ff      <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NREL; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         armed_ff     <= armed_in;
         note_ff      <= note_in;
         fire_ff      <= fire_in;
         tell_ff      <= tell_in;
         walk_ff      <= walk_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== src/relay_bank_timed_revert.sv =====
// A request passes the front hold register and the two-entry queue to the back sequencer's
// command register; its first result is then registered in the result register (a tick
// first updates all relays at once). A tick then walks the relays up to and including the
// highest one restored, giving a drive result and, if wanted, a notice for each restored one.
// The back sequencer handles one request at a time; a two-entry queue decouples the front.
// Reset (synchronous) clears every relay state and disarms every relay, and sets relay_count to 8.
module relay_bank_timed_revert #(
   parameter int RELAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // relay_number, new_state, requester, hold_seconds, revert_wanted, notify_wanted
   input  logic [rbtr_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // relay, drive_state, owner, relay_states
   output logic [rbtr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbtr_pkg::COUNT_W-1:0]    csr_data
);
   import rbtr_pkg::*;

   localparam int NREL = (RELAYS < MAX_RELAYS) ? RELAYS : MAX_RELAYS;

   logic [COUNT_W-1:0] relay_count_ff, relay_count_in;
   logic               q_push, q_ready, q_valid, q_pop;
   cmd_type            push_cmd, pop_cmd;
   rsp_type            rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      relay_count_in = relay_count_ff;
      if (csr_valid && csr_ready) begin
         relay_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_count_ff <= COUNT_W'(MAX_RELAYS);
      end else begin
         relay_count_ff <= relay_count_in;
      end
   end

   rbtr_front #(.NREL(NREL)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .relay_count (relay_count_ff),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   rbtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .push_ready (q_ready),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (pop_cmd)
   );

   rbtr_back #(.NREL(NREL)) u_back (
      .clock       (clock),
      .reset       (reset),
      .relay_count (relay_count_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_cmd       (pop_cmd),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {4'b0, rsp.relay_states, rsp.owner, rsp.drive_state, rsp.relay};

endmodule

// ===== src/rbtr_checker.sv =====
// Port-level checker for the relay bank, bound to the top level.
`include "relay_bank_timed_revert_macros.svh"

module rbtr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rbtr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast
);
   import rbtr_pkg::*;

   logic                  rsp_stall;
   logic [RSP_DATA_W+2:0] rsp_bus;
   logic                  is_status;
   logic                  is_notice;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_bus   = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign is_status = rsp_tvalid && rsp_tuser == KIND_STATUS;
   assign is_notice = rsp_tvalid && rsp_tuser == KIND_NOTICE;

   `RBTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_bus))
   `RBTR_ASSERT_IMPLY(a_status_last, clock, reset, is_status, rsp_tlast && !(|rsp_tdata[11:0]))
   `RBTR_ASSERT_IMPLY(a_notice_clean, clock, reset, is_notice, !(|rsp_tdata[19:12]))

endmodule

bind relay_bank_timed_revert rbtr_checker u_checker (.*);

// ===== test/relay_bank_timed_revert_test.sv =====
// Testbench for the relay bank with timed revert: directed and random requests, scoreboard check.
`timescale 1ns / 100ps

module relay_bank_timed_revert_test;
   import rbtr_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int SETTLE_CYCLES = 40;

   class relay_scoreboard;
      rsp_type           expected_q[$];
      rsp_type           batch[$];
      logic              cur_contact[MAX_RELAYS];
      logic              prev_contact[MAX_RELAYS];
      logic              armed[MAX_RELAYS];
      logic [CNT_W-1:0]  seconds_left[MAX_RELAYS];
      logic              notice_on[MAX_RELAYS];
      logic [OWNER_W-1:0] owner_code[MAX_RELAYS];
      logic [COUNT_W-1:0] relay_count;
      int                failures;

      function new();
         for (int i = 0; i < MAX_RELAYS; i++) begin
            cur_contact[i] = 1'b0;
            prev_contact[i] = 1'b0;
            disarm(i);
         end
         relay_count = 4'd8;
         failures = 0;
      endfunction

      function void disarm(int i);
         armed[i] = 1'b0;
         seconds_left[i] = '0;
         notice_on[i] = 1'b0;
         owner_code[i] = '0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] v);
         relay_count = v;
      endfunction

      function int usable();
         return (relay_count > MAX_RELAYS) ? MAX_RELAYS : int'(relay_count);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void add_result(kind_type k, int relay, logic drive, logic [OWNER_W-1:0] owner,
                               logic [WORD_W-1:0] word);
         rsp_type r;
         r.kind = k;
         r.relay = relay[RELAY_W-1:0];
         r.drive_state = drive;
         r.owner = owner;
         r.relay_states = word;
         r.last = 1'b0;
         batch.push_back(r);
      endfunction

      function void note_request(func_type f, logic [REQ_DATA_W-1:0] d);
         logic [NUM_W-1:0]   num;
         logic               ns;
         logic [OWNER_W-1:0] req;
         logic [HOLD_W-1:0]  hold;
         logic               rev;
         logic               ntf;
         logic               tell;
         logic [WORD_W-1:0]  word;
         rsp_type            tail;
         int                 n;
         int                 i;
         num = d[7:0];
         ns = d[8];
         req = d[16:9];
         hold = d[24:17];
         rev = d[25];
         ntf = d[26];
         n = usable();
         batch.delete();
         case (f)
            FUNC_PLAIN, FUNC_TIMED: begin
               if (num != 0 && int'(num) <= n) begin
                  i = int'(num) - 1;
                  if (ns != cur_contact[i]) begin
                     add_result(KIND_DRIVE, i, ns, '0, '0);
                     if (f == FUNC_TIMED && rev) begin
                        owner_code[i] = req;
                        prev_contact[i] = cur_contact[i];
                        cur_contact[i] = ns;
                        armed[i] = 1'b1;
                        seconds_left[i] = {1'b0, hold} + 9'd1;
                        notice_on[i] = ntf;
                     end else begin
                        if (f == FUNC_PLAIN && armed[i] && seconds_left[i] != 0 && notice_on[i])
                           add_result(KIND_NOTICE, i, 1'b0, req, '0);
                        prev_contact[i] = cur_contact[i];
                        cur_contact[i] = ns;
                        disarm(i);
                     end
                  end
               end
            end
            FUNC_TICK: begin
               for (i = 0; i < n; i++) begin
                  if (armed[i]) begin
                     if (seconds_left[i] != 0)
                        seconds_left[i] = seconds_left[i] - 9'd1;
                     if (seconds_left[i] == 0 && prev_contact[i] != cur_contact[i]) begin
                        add_result(KIND_DRIVE, i, prev_contact[i], '0, '0);
                        cur_contact[i] = prev_contact[i];
                        tell = notice_on[i];
                        disarm(i);
                        if (tell)
                           add_result(KIND_NOTICE, i, 1'b0, '0, '0);
                     end
                  end
               end
            end
            default: begin
               word = '0;
               for (i = 0; i < n; i++)
                  word[i] = cur_contact[i];
               add_result(KIND_STATUS, 0, 1'b0, '0, word);
            end
         endcase
         if (batch.size() > 0) begin
            tail = batch.pop_back();
            tail.last = 1'b1;
            batch.push_back(tail);
         end
         foreach (batch[k])
            expected_q.push_back(batch[k]);
      endfunction

      function void check_response(logic [1:0] kind, logic [RSP_DATA_W-1:0] d, logic last);
         rsp_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected result: kind %0d data %h last %0d", kind, d, last);
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind || d[2:0] !== want.relay || d[3] !== want.drive_state ||
             d[11:4] !== want.owner || d[19:12] !== want.relay_states || last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("Mismatch: expected kind %0d relay %0d drive %0d owner %h word %h last %0d",
                        want.kind, want.relay, want.drive_state, want.owner, want.relay_states,
                        want.last);
               $display("          got kind %0d relay %0d drive %0d owner %h word %h last %0d",
                        kind, d[2:0], d[3], d[11:4], d[19:12], last);
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data = '0;

   relay_scoreboard sb;
   int  cycle_count = 0;
   int  stall_mode = 0;
   int  stall_phase = 0;
   int  burst_left = 0;
   bit  gaps_on = 1'b1;

   relay_bank_timed_revert #(
      .RELAYS(MAX_RELAYS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase % 128 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (stall_phase % 8 == 0);
         default: rsp_tready <= (stall_phase % 32 >= 16);
      endcase
   end

   task automatic send(func_type f, logic [NUM_W-1:0] num, logic ns, logic [OWNER_W-1:0] req,
                       logic [HOLD_W-1:0] hold, logic rev, logic ntf);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      req_tuser = f;
      req_tdata = {5'b0, ntf, rev, hold, req, ns, num};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(f, req_tdata);
      burst_left--;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_relay_count(logic [COUNT_W-1:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random();
      func_type f;
      int       pick;
      int       n;
      int       i;
      logic [NUM_W-1:0]  num;
      logic              ns;
      logic [HOLD_W-1:0] hold;
      pick = $urandom_range(0, 99);
      n = sb.usable();
      if (pick < 30)
         f = FUNC_PLAIN;
      else if (pick < 60)
         f = FUNC_TIMED;
      else if (pick < 90)
         f = FUNC_TICK;
      else
         f = FUNC_STATUS;
      pick = $urandom_range(0, 99);
      if (pick < 80 && n > 0)
         num = NUM_W'($urandom_range(1, n));
      else if (pick < 95)
         num = NUM_W'($urandom_range(0, 255));
      else
         num = '0;
      if (num != 0 && int'(num) <= n && $urandom_range(0, 3) != 0) begin
         i = int'(num) - 1;
         ns = ~sb.cur_contact[i];
      end else begin
         ns = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
         hold = HOLD_W'($urandom_range(0, 3));
      else if (pick < 90)
         hold = HOLD_W'($urandom_range(0, 15));
      else
         hold = HOLD_W'($urandom_range(0, 255));
      send(f, num, ns, OWNER_W'($urandom_range(0, 255)), hold, $urandom_range(0, 99) < 85,
           1'($urandom_range(0, 1)));
   endtask

   initial begin
      int phase_count[7];
      int phase_items[7];
      sb = new();
      phase_count = '{8, 3, 15, 1, 0, 5, 8};
      phase_items = '{45, 45, 45, 30, 15, 45, 45};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_relay_count(4'd8);
      send(FUNC_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_PLAIN, 8'd1, 1'b1, 8'hFF, 8'd0, 1'b0, 1'b0);
      send(FUNC_PLAIN, 8'd1, 1'b1, 8'h11, 8'd0, 1'b0, 1'b0);
      send(FUNC_PLAIN, 8'd0, 1'b1, 8'h22, 8'd0, 1'b0, 1'b0);
      send(FUNC_PLAIN, 8'd9, 1'b1, 8'h33, 8'd0, 1'b0, 1'b0);
      send(FUNC_TIMED, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1);
      send(FUNC_TIMED, 8'd8, 1'b1, 8'hAA, 8'd0, 1'b1, 1'b1);
      send(FUNC_TICK, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_TIMED, 8'd2, 1'b1, 8'h55, 8'hFF, 1'b1, 1'b1);
      send(FUNC_PLAIN, 8'd2, 1'b0, 8'h81, 8'd0, 1'b0, 1'b0);
      send(FUNC_TIMED, 8'd3, 1'b1, 8'h42, 8'd1, 1'b1, 1'b0);
      send(FUNC_TIMED, 8'd3, 1'b0, 8'h43, 8'd2, 1'b1, 1'b1);
      repeat (3) send(FUNC_TICK, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_TIMED, 8'd4, 1'b1, 8'h44, 8'd3, 1'b1, 1'b1);
      send(FUNC_TIMED, 8'd4, 1'b0, 8'h45, 8'd0, 1'b0, 1'b1);
      send(FUNC_TIMED, 8'd5, 1'b1, 8'h55, 8'd0, 1'b1, 1'b1);
      send(FUNC_TIMED, 8'd6, 1'b1, 8'h66, 8'd0, 1'b1, 1'b0);
      send(FUNC_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      wait_idle();
      write_relay_count(4'd2);
      send(FUNC_TICK, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      wait_idle();
      write_relay_count(4'd15);
      send(FUNC_TICK, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      wait_idle();
      write_relay_count(4'd0);
      send(FUNC_PLAIN, 8'd1, 1'b0, 8'h12, 8'd0, 1'b0, 1'b0);
      send(FUNC_TICK, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      send(FUNC_STATUS, 8'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0);
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         write_relay_count(COUNT_W'(phase_count[p]));
         gaps_on = (p != 1);
         for (int k = 0; k < phase_items[p]; k++) begin
            if (k == 20)
               wait_idle();
            send_random();
         end
         wait_idle();
      end

      if (sb.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/rbtr_pkg.sv
src/rbtr_queue.sv
src/rbtr_front.sv
src/rbtr_back.sv
src/relay_bank_timed_revert.sv
src/rbtr_checker.sv
test/relay_bank_timed_revert_test.sv
